// ----- hdl/jdsm_pkg.sv -----
`timescale 1ns / 1ps

package jdsm_pkg;

  // Converter width and quantization step of the raw samples.
  localparam int ADC_BITS   = 12;
  localparam int QUANT_STEP = 5;
  localparam int SPEED_W    = 10;
  localparam int CFG_IDX_W  = 3;

  // Reciprocal used for the divide by the quantization step.
  localparam int QSH    = ADC_BITS + 4;
  localparam int QRECIP = ((1 << QSH) + QUANT_STEP - 1) / QUANT_STEP;
  localparam int QPW    = 2 * ADC_BITS + 5;

  // Product of deflection and speed span, and the radix-4 divider built on it.
  localparam int PROD_W    = ADC_BITS + SPEED_W;
  localparam int DIV_ITERS = (PROD_W + 1) / 2;
  localparam int DVD_W     = 2 * DIV_ITERS;

  typedef enum logic [2:0] {
    OP_DRIVE    = 3'd0,
    OP_DEFAULTS = 3'd1,
    OP_CENTER   = 3'd2,
    OP_RANGE    = 3'd3,
    OP_VALIDATE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_STOP     = 2'd1,
    CMD_FORWARD  = 2'd2,
    CMD_BACKWARD = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_LOW       = 3'd2,
    REG_HIGH      = 3'd3,
    REG_DEAD_BAND = 3'd4,
    REG_SPEED_MIN = 3'd5,
    REG_SPEED_MAX = 3'd6
  } reg_e;

  // What one axis lane hands to the merging stage.
  typedef struct packed {
    logic               done;
    logic               above;
    logic [SPEED_W-1:0] speed;
  } lane_res_t;

  // Rounds a sample down to a multiple of the quantization step. The
  // reciprocal is rounded up, so the estimate is at most one step high.
  function automatic logic [ADC_BITS-1:0] quantize(input logic [ADC_BITS-1:0] v);
    logic [QPW-1:0]    prod;
    logic [ADC_BITS:0] m;
    prod = QPW'(v) * QPW'(QRECIP);
    m    = (ADC_BITS + 1)'((prod >> QSH) * QUANT_STEP);
    if (m > {1'b0, v}) begin
      m = m - (ADC_BITS + 1)'(QUANT_STEP);
    end
    return m[ADC_BITS-1:0];
  endfunction

endpackage

// ----- hdl/jdsm_lane.sv -----
`timescale 1ns / 1ps

module jdsm_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]    value_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]    center_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]    low_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]    high_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]    dead_band_i,
  input  logic [jdsm_pkg::SPEED_W-1:0]     speed_min_i,
  input  logic [jdsm_pkg::SPEED_W-1:0]     speed_max_i,
  output jdsm_pkg::lane_res_t              res_o
);
  import jdsm_pkg::*;

  localparam int SW    = ADC_BITS + 2;
  localparam int SPW   = SPEED_W + 2;
  localparam int RW    = DVD_W + 2;
  localparam int CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_MUL,
    LS_DIV,
    LS_FIN
  } lstate_e;

  lstate_e lstate_q;

  logic [ADC_BITS-1:0] nm_q, div_q, rem_q;
  logic [SPEED_W-1:0]  dm_q, base_q, speed_q;
  logic                neg_q, zero_q, above_q, done_q;
  logic [DVD_W-1:0]    dvd_q, quo_q;
  logic [CNT_W-1:0]    cnt_q;

  // Operand setup: dead band snap, direction, and the signed terms of the map.
  logic signed [SW-1:0]  v_s, c_s, lo_s, hi_s, db_s, vv, n, span;
  logic signed [SPW-1:0] smin_s, smax_s, d;
  logic                  win, above;
  logic [SPEED_W-1:0]    base;

  always_comb begin
    v_s    = $signed({2'b00, value_i});
    c_s    = $signed({2'b00, center_i});
    lo_s   = $signed({2'b00, low_i});
    hi_s   = $signed({2'b00, high_i});
    db_s   = $signed({2'b00, dead_band_i});
    smin_s = $signed({2'b00, speed_min_i});
    smax_s = $signed({2'b00, speed_max_i});
    win    = (v_s > c_s - db_s) && (v_s < c_s + db_s);
    vv     = win ? c_s : v_s;
    above  = vv > c_s;
    if (above) begin
      n    = vv - c_s;
      span = hi_s - c_s;
      d    = smax_s - smin_s;
      base = speed_min_i;
    end else begin
      n    = vv - lo_s;
      span = c_s - lo_s;
      d    = smin_s - smax_s;
      base = speed_max_i;
    end
  end

  logic [SW-1:0]  n_abs, span_abs;
  logic [SPW-1:0] d_abs;

  assign n_abs    = n[SW-1] ? SW'(-n) : SW'(n);
  assign span_abs = span[SW-1] ? SW'(-span) : SW'(span);
  assign d_abs    = d[SPW-1] ? SPW'(-d) : SPW'(d);

  // Two restoring division steps per cycle.
  logic [ADC_BITS-1:0] rem_n;
  logic [ADC_BITS:0]   trial;
  logic [1:0]          qbits;

  always_comb begin
    rem_n = rem_q;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_n, dvd_q[DVD_W-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial        = trial - {1'b0, div_q};
        qbits[1 - i] = 1'b1;
      end
      rem_n = trial[ADC_BITS-1:0];
    end
  end

  // Signed result, offset and clamp.
  logic signed [RW-1:0] q_s, r_s, lo_b, hi_b;
  logic [SPEED_W-1:0]   speed_n;

  always_comb begin
    q_s  = $signed({2'b00, quo_q});
    q_s  = neg_q ? -q_s : q_s;
    r_s  = q_s + $signed(RW'(base_q));
    lo_b = (speed_min_i < speed_max_i) ? $signed(RW'(speed_min_i))
                                       : $signed(RW'(speed_max_i));
    hi_b = (speed_min_i < speed_max_i) ? $signed(RW'(speed_max_i))
                                       : $signed(RW'(speed_min_i));
    if (r_s < lo_b) begin
      r_s = lo_b;
    end
    if (r_s > hi_b) begin
      r_s = hi_b;
    end
    speed_n = zero_q ? speed_min_i : r_s[SPEED_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lstate_q <= LS_IDLE;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= (lstate_q == LS_FIN);
      case (lstate_q)
        LS_IDLE: begin
          if (start_i) begin
            lstate_q <= LS_MUL;
          end
        end
        LS_MUL: begin
          cnt_q    <= '0;
          lstate_q <= LS_DIV;
        end
        LS_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_ITERS - 1)) begin
            lstate_q <= LS_FIN;
          end
        end
        LS_FIN: begin
          lstate_q <= LS_IDLE;
        end
        default: lstate_q <= LS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (lstate_q)
      LS_IDLE: begin
        if (start_i) begin
          nm_q    <= n_abs[ADC_BITS-1:0];
          dm_q    <= d_abs[SPEED_W-1:0];
          div_q   <= span_abs[ADC_BITS-1:0];
          neg_q   <= n[SW-1] ^ d[SPW-1] ^ span[SW-1];
          zero_q  <= (span == '0);
          base_q  <= base;
          above_q <= above;
        end
      end
      LS_MUL: begin
        dvd_q <= DVD_W'(nm_q) * DVD_W'(dm_q);
        rem_q <= '0;
        quo_q <= '0;
      end
      LS_DIV: begin
        dvd_q <= dvd_q << 2;
        quo_q <= {quo_q[DVD_W-3:0], qbits};
        rem_q <= rem_n;
      end
      LS_FIN: begin
        speed_q <= speed_n;
      end
      default: ;
    endcase
  end

  assign res_o.done  = done_q;
  assign res_o.above = above_q;
  assign res_o.speed = speed_q;

endmodule

// ----- hdl/jdsm_merge.sv -----
`timescale 1ns / 1ps

module jdsm_merge (
  input  jdsm_pkg::lane_res_t            lane_x_i,
  input  jdsm_pkg::lane_res_t            lane_y_i,
  input  logic [jdsm_pkg::SPEED_W-1:0]   speed_min_i,
  output jdsm_pkg::cmd_e                 command_o
);
  import jdsm_pkg::*;

  // Both axes at or below the center speed means stop; otherwise only the
  // Y direction decides between forward and backward.
  always_comb begin
    if (lane_x_i.speed <= speed_min_i && lane_y_i.speed <= speed_min_i) begin
      command_o = CMD_STOP;
    end else if (lane_y_i.above) begin
      command_o = CMD_FORWARD;
    end else begin
      command_o = CMD_BACKWARD;
    end
  end

endmodule

// ----- hdl/joystick_deadband_speed_mapper.sv -----
`timescale 1ns / 1ps
// Channel | Handshake                   | Word
// --------+-----------------------------+---------------------------------------------
// in      | in_valid_i / in_ready_o     | opcode_i, raw_x_i, raw_y_i
// out     | out_valid_o / out_ready_i   | command_o, speed_a_o, speed_b_o, calib_ok_o
// cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// A drive word while started has its result set by the radix-4 divider in each axis
// lane (a multiply step and 11 iterations), then passes through the wait and hold states.
// Every other word goes from execution straight to the hold state.
// One word is worked on at a time; the next is accepted in the cycle after the previous
// result is loaded, while it may still wait in the output register. A full output register
// stalls the loading of the next result.
// Reset is asynchronous and active low and loads the register reset values and the
// default calibration, stopped. The configuration channel is always ready.

module joystick_deadband_speed_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          opcode_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]       raw_x_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]       raw_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          command_o,
  output logic [jdsm_pkg::SPEED_W-1:0]        speed_a_o,
  output logic [jdsm_pkg::SPEED_W-1:0]        speed_b_o,
  output logic                                calib_ok_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jdsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jdsm_pkg::ADC_BITS-1:0]       cfg_data_i
);
  import jdsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_HOLD
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [ADC_BITS-1:0] def_cx_q, def_cy_q, def_low_q, def_high_q, dead_band_q;
  logic [SPEED_W-1:0]  speed_min_q, speed_max_q;

  // Calibration state.
  logic [ADC_BITS-1:0] center_x_q, center_y_q, low_x_q, low_y_q, high_x_q, high_y_q;
  logic                started_q;

  // The accepted word, quantized on the way in.
  logic [2:0]          op_q;
  logic [ADC_BITS-1:0] x_q, y_q;

  // Result waiting for the output register, and the output register itself.
  logic [1:0]          res_cmd_q, cmd_q;
  logic [SPEED_W-1:0]  res_sa_q, res_sb_q, sa_q, sb_q;
  logic                res_ok_q, ok_q, out_valid_q;

  lane_res_t lane_x, lane_y;
  cmd_e      merged_cmd;
  logic      lane_start, cal_bad;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign out_valid_o = out_valid_q;
  assign command_o   = cmd_q;
  assign speed_a_o   = sa_q;
  assign speed_b_o   = sb_q;
  assign calib_ok_o  = ok_q;

  // Both lanes start together, only for a drive word while started.
  assign lane_start = (state_q == ST_EXEC) && (op_q == OP_DRIVE) && started_q;

  // Validation looks at the X axis only.
  assign cal_bad = (center_x_q == '0) || (low_x_q == center_x_q) ||
                   (high_x_q == low_x_q) || (high_x_q == center_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_cx_q    <= ADC_BITS'(2048);
      def_cy_q    <= ADC_BITS'(2048);
      def_low_q   <= '0;
      def_high_q  <= ADC_BITS'(4095);
      dead_band_q <= ADC_BITS'(100);
      speed_min_q <= '0;
      speed_max_q <= SPEED_W'(255);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_X:  def_cx_q    <= cfg_data_i;
        REG_CENTER_Y:  def_cy_q    <= cfg_data_i;
        REG_LOW:       def_low_q   <= cfg_data_i;
        REG_HIGH:      def_high_q  <= cfg_data_i;
        REG_DEAD_BAND: dead_band_q <= cfg_data_i;
        REG_SPEED_MIN: speed_min_q <= cfg_data_i[SPEED_W-1:0];
        REG_SPEED_MAX: speed_max_q <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      center_x_q  <= ADC_BITS'(2048);
      center_y_q  <= ADC_BITS'(2048);
      low_x_q     <= '0;
      low_y_q     <= '0;
      high_x_q    <= ADC_BITS'(4095);
      high_y_q    <= ADC_BITS'(4095);
      started_q   <= 1'b0;
      op_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      res_cmd_q   <= '0;
      res_sa_q    <= '0;
      res_sb_q    <= '0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      ok_q        <= 1'b0;
    end else begin
      // The hold state reloads the output register itself whenever it is taken.
      if (out_ready_i && state_q != ST_HOLD) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            x_q     <= quantize(raw_x_i);
            y_q     <= quantize(raw_y_i);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // Anything but a started drive answers with zero speeds and no command.
          res_cmd_q <= CMD_NONE;
          res_sa_q  <= '0;
          res_sb_q  <= '0;
          res_ok_q  <= (op_q == OP_VALIDATE) && !cal_bad;
          state_q   <= ((op_q == OP_DRIVE) && started_q) ? ST_WAIT : ST_HOLD;
          case (op_q)
            OP_DEFAULTS: begin
              center_x_q <= def_cx_q;
              center_y_q <= def_cy_q;
              low_x_q    <= def_low_q;
              low_y_q    <= def_low_q;
              high_x_q   <= def_high_q;
              high_y_q   <= def_high_q;
              started_q  <= 1'b1;
            end
            OP_CENTER: begin
              center_x_q <= x_q;
              low_x_q    <= x_q;
              high_x_q   <= x_q;
              center_y_q <= y_q;
              low_y_q    <= y_q;
              high_y_q   <= y_q;
            end
            OP_RANGE: begin
              if (x_q < low_x_q)  low_x_q  <= x_q;
              if (y_q < low_y_q)  low_y_q  <= y_q;
              if (x_q > high_x_q) high_x_q <= x_q;
              if (y_q > high_y_q) high_y_q <= y_q;
            end
            OP_VALIDATE: begin
              if (cal_bad) begin
                center_x_q <= def_cx_q;
                center_y_q <= def_cy_q;
                low_x_q    <= def_low_q;
                low_y_q    <= def_low_q;
                high_x_q   <= def_high_q;
                high_y_q   <= def_high_q;
                started_q  <= 1'b0;
              end else begin
                started_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_WAIT: begin
          if (lane_x.done) begin
            res_cmd_q <= merged_cmd;
            res_sa_q  <= lane_x.speed;
            res_sb_q  <= lane_y.speed;
            res_ok_q  <= 1'b0;
            state_q   <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // Move the result out as soon as the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            cmd_q       <= res_cmd_q;
            sa_q        <= res_sa_q;
            sb_q        <= res_sb_q;
            ok_q        <= res_ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  jdsm_lane u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (lane_start),
    .value_i     (x_q),
    .center_i    (center_x_q),
    .low_i       (low_x_q),
    .high_i      (high_x_q),
    .dead_band_i (dead_band_q),
    .speed_min_i (speed_min_q),
    .speed_max_i (speed_max_q),
    .res_o       (lane_x)
  );

  jdsm_lane u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (lane_start),
    .value_i     (y_q),
    .center_i    (center_y_q),
    .low_i       (low_y_q),
    .high_i      (high_y_q),
    .dead_band_i (dead_band_q),
    .speed_min_i (speed_min_q),
    .speed_max_i (speed_max_q),
    .res_o       (lane_y)
  );

  jdsm_merge u_merge (
    .lane_x_i    (lane_x),
    .lane_y_i    (lane_y),
    .speed_min_i (speed_min_q),
    .command_o   (merged_cmd)
  );

  // The two lanes run in lock step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_x.done == lane_y.done)
    else $error("axis lanes finished in different cycles");

  // A lane only finishes while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_x.done |-> state_q == ST_WAIT)
    else $error("lane result arrived outside the wait state");

  // Words without a command carry zero speeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_NONE |-> speed_a_o == '0 && speed_b_o == '0)
    else $error("nonzero speed on a word without a command");

  // A passed validation never comes with a drive command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calib_ok_o |-> command_o == CMD_NONE)
    else $error("calibration pass flagged on a drive result");

  // A word is only accepted when no earlier one is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC)
    else $error("accepted word did not enter execution");

endmodule
